// ===== src/qvt_pkg.sv =====
// Package for the quadrilateral vertex transformer.
// Holds widths, action codes, sequencer states and the CORDIC arctangent table.
package qvt_pkg;

	localparam int CW = 24;
	localparam int AW = 18;
	localparam int STEPS = 16;
	localparam int SW = $clog2(STEPS);
	localparam int EXT = CW + 16 + 2;
	localparam int ZW = 28;
	localparam int FULL_TURN = 92160;
	localparam int QUARTER_TURN = 23040;
	localparam int GAIN_Q30 = 652032874;

	typedef enum logic [2:0] {
		ACT_SET    = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_ROTATE = 3'd2,
		ACT_SCALE  = 3'd3,
		ACT_MOVE   = 3'd4,
		ACT_CENTER = 3'd5,
		ACT_READ   = 3'd6,
		ACT_SPARE  = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LOAD,
		ST_GAIN,
		ST_ITER,
		ST_STORE,
		ST_DONE
	} state_t;

	// Control from the sequencer to the CORDIC unit.
	typedef struct packed {
		logic           load;
		logic           gain;
		logic           iter;
		logic [SW-1:0]  step;
		logic [1:0]     quad;
	} cordic_ctl_t;

	function automatic logic [ZW-1:0] atan_lut(input logic [4:0] k);
		logic [ZW-1:0] v;
		unique case (k)
			5'd0:  v = 28'd47185920;
			5'd1:  v = 28'd27855475;
			5'd2:  v = 28'd14718068;
			5'd3:  v = 28'd7471121;
			5'd4:  v = 28'd3750058;
			5'd5:  v = 28'd1876857;
			5'd6:  v = 28'd938658;
			5'd7:  v = 28'd469357;
			5'd8:  v = 28'd234682;
			5'd9:  v = 28'd117342;
			5'd10: v = 28'd58671;
			5'd11: v = 28'd29335;
			5'd12: v = 28'd14668;
			5'd13: v = 28'd7334;
			5'd14: v = 28'd3667;
			5'd15: v = 28'd1833;
			5'd16: v = 28'd917;
			5'd17: v = 28'd458;
			5'd18: v = 28'd229;
			5'd19: v = 28'd115;
			5'd20: v = 28'd57;
			5'd21: v = 28'd29;
			5'd22: v = 28'd14;
			5'd23: v = 28'd7;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [CW-1:0] sat(input logic signed [EXT-1:0] v);
		logic signed [EXT-1:0] hi;
		logic signed [EXT-1:0] lo;
		hi = EXT'((64'sd1 <<< (CW - 1)) - 1);
		lo = -hi - 1;
		if (v > hi) return hi[CW-1:0];
		if (v < lo) return lo[CW-1:0];
		return v[CW-1:0];
	endfunction

endpackage

// ===== src/qvt_cordic.sv =====
// Shared rotation unit: gain multiply, quadrant swap and one CORDIC step per cycle.
// Depends on qvt_pkg.
module qvt_cordic (
	input  logic                              clk,
	input  qvt_pkg::cordic_ctl_t              ctl,
	input  logic signed [qvt_pkg::CW:0]       dx,
	input  logic signed [qvt_pkg::CW:0]       dy,
	input  logic signed [qvt_pkg::ZW-1:0]     z0,
	output logic signed [qvt_pkg::EXT-1:0]    x_out,
	output logic signed [qvt_pkg::EXT-1:0]    y_out
);

	localparam int EXT = qvt_pkg::EXT;
	localparam int ZW = qvt_pkg::ZW;

	logic signed [EXT-1:0] x_q, y_q;
	logic signed [ZW-1:0]  z_q;
	logic signed [qvt_pkg::CW:0] dx_q, dy_q;
	logic signed [qvt_pkg::CW+31:0] px, py;
	logic signed [EXT-1:0] gx, gy, xs, ys;

	// Gain multiply: one multiplier per axis, then quadrant rotation.
	assign px = dx_q * $signed(31'(qvt_pkg::GAIN_Q30));
	assign py = dy_q * $signed(31'(qvt_pkg::GAIN_Q30));
	assign gx = EXT'(px >>> 14);
	assign gy = EXT'(py >>> 14);
	assign xs = x_q >>> ctl.step;
	assign ys = y_q >>> ctl.step;

	// One shared iteration register set.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dx_q <= dx;
			dy_q <= dy;
			z_q  <= z0;
		end else if (ctl.gain) begin
			unique case (ctl.quad)
				2'd0: begin x_q <= gx;  y_q <= gy;  end
				2'd1: begin x_q <= -gy; y_q <= gx;  end
				2'd2: begin x_q <= -gx; y_q <= -gy; end
				default: begin x_q <= gy; y_q <= -gx; end
			endcase
		end else if (ctl.iter) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed(qvt_pkg::atan_lut(5'(ctl.step)));
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed(qvt_pkg::atan_lut(5'(ctl.step)));
			end
		end
	end

	// Round half up back to Q15.8.
	assign x_out = (x_q + EXT'(32768)) >>> 16;
	assign y_out = (y_q + EXT'(32768)) >>> 16;

endmodule

// ===== src/quad_vertex_transform_top.sv =====
// Quadrilateral vertex transformer: corner storage, sequencer and simple ops.
// Depends on qvt_pkg and qvt_cordic.
// To out_valid: set, add, translate, read: REDUCE, DONE; scale, move center: REDUCE, STORE
// per corner, DONE; rotate: REDUCE, LOAD, DONE for a zero angle, else REDUCE, then per corner
// LOAD, GAIN, ITER, STORE (LOAD alone on the pivot), DONE. No new item is taken before idle.
// in_ready is high only in idle. Reset (arst_n low) clears all corners and returns to idle.
module quad_vertex_transform_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    action,
	input  logic signed [qvt_pkg::CW-1:0] corner0_x,
	input  logic signed [qvt_pkg::CW-1:0] corner0_y,
	input  logic signed [qvt_pkg::CW-1:0] corner1_x,
	input  logic signed [qvt_pkg::CW-1:0] corner1_y,
	input  logic signed [qvt_pkg::CW-1:0] corner2_x,
	input  logic signed [qvt_pkg::CW-1:0] corner2_y,
	input  logic signed [qvt_pkg::CW-1:0] corner3_x,
	input  logic signed [qvt_pkg::CW-1:0] corner3_y,
	input  logic signed [qvt_pkg::CW-1:0] point_x,
	input  logic signed [qvt_pkg::CW-1:0] point_y,
	input  logic signed [qvt_pkg::AW-1:0] amount,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [qvt_pkg::CW-1:0] out_corner0_x,
	output logic signed [qvt_pkg::CW-1:0] out_corner0_y,
	output logic signed [qvt_pkg::CW-1:0] out_corner1_x,
	output logic signed [qvt_pkg::CW-1:0] out_corner1_y,
	output logic signed [qvt_pkg::CW-1:0] out_corner2_x,
	output logic signed [qvt_pkg::CW-1:0] out_corner2_y,
	output logic signed [qvt_pkg::CW-1:0] out_corner3_x,
	output logic signed [qvt_pkg::CW-1:0] out_corner3_y,
	output logic signed [qvt_pkg::CW-1:0] center_x,
	output logic signed [qvt_pkg::CW-1:0] center_y
);

	localparam int CW = qvt_pkg::CW;
	localparam int EXT = qvt_pkg::EXT;
	localparam int ZW = qvt_pkg::ZW;
	localparam int SW = qvt_pkg::SW;
	localparam int AW_L = qvt_pkg::AW;

	qvt_pkg::state_t state_q, state_d;
	qvt_pkg::action_t act_q;
	logic signed [CW-1:0] vx_q [4];
	logic signed [CW-1:0] vy_q [4];
	logic signed [CW-1:0] px_q, py_q;
	logic signed [AW_L-1:0] amt_q;
	logic [1:0]    idx_q;
	logic [SW-1:0] step_q;
	logic [1:0]    quad_q;
	logic [ZW-1:0] rest_q;
	logic signed [CW-1:0] sx_q, sy_q;
	logic signed [CW+1:0] sumx, sumy;
	logic signed [CW:0] dx, dy;
	logic signed [EXT-1:0] rx, ry;
	logic signed [CW+AW_L-1:0] mx, my;
	logic signed [AW_L:0] amod;
	qvt_pkg::cordic_ctl_t ctl;
	logic on_pivot;

	assign sumx = (CW+2)'(vx_q[0]) + (CW+2)'(vx_q[1]) + (CW+2)'(vx_q[2]) + (CW+2)'(vx_q[3]);
	assign sumy = (CW+2)'(vy_q[0]) + (CW+2)'(vy_q[1]) + (CW+2)'(vy_q[2]) + (CW+2)'(vy_q[3]);
	assign dx = (CW+1)'(vx_q[idx_q]) - (CW+1)'(px_q);
	assign dy = (CW+1)'(vy_q[idx_q]) - (CW+1)'(py_q);
	assign on_pivot = (dx == '0) && (dy == '0);
	assign mx = vx_q[idx_q] * amt_q;
	assign my = vy_q[idx_q] * amt_q;

	// Angle reduction into [0, full turn): amount is within two turns of zero.
	always_comb begin
		amod = (AW_L+1)'(amt_q);
		if (amod < 0) amod = amod + (AW_L+1)'(qvt_pkg::FULL_TURN);
		if (amod >= (AW_L+1)'(qvt_pkg::FULL_TURN))
			amod = amod - (AW_L+1)'(qvt_pkg::FULL_TURN);
		if (amod < 0) amod = amod + (AW_L+1)'(qvt_pkg::FULL_TURN);
	end

	assign ctl.load = (state_q == qvt_pkg::ST_LOAD);
	assign ctl.gain = (state_q == qvt_pkg::ST_GAIN);
	assign ctl.iter = (state_q == qvt_pkg::ST_ITER);
	assign ctl.step = step_q;
	assign ctl.quad = quad_q;

	qvt_cordic u_cordic (
		.clk   (clk),
		.ctl   (ctl),
		.dx    (dx),
		.dy    (dy),
		.z0    ($signed(rest_q)),
		.x_out (rx),
		.y_out (ry)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qvt_pkg::ST_IDLE:   if (in_valid) state_d = qvt_pkg::ST_REDUCE;
			qvt_pkg::ST_REDUCE: begin
				if (act_q == qvt_pkg::ACT_ROTATE) state_d = qvt_pkg::ST_LOAD;
				else if (act_q == qvt_pkg::ACT_SCALE || act_q == qvt_pkg::ACT_CENTER)
					state_d = qvt_pkg::ST_STORE;
				else state_d = qvt_pkg::ST_DONE;
			end
			qvt_pkg::ST_LOAD: begin
				if (amod == '0) state_d = qvt_pkg::ST_DONE;
				else if (on_pivot) state_d = (idx_q == 2'd3) ? qvt_pkg::ST_DONE : qvt_pkg::ST_LOAD;
				else state_d = qvt_pkg::ST_GAIN;
			end
			qvt_pkg::ST_GAIN:   state_d = qvt_pkg::ST_ITER;
			qvt_pkg::ST_ITER:   if (step_q == SW'(qvt_pkg::STEPS - 1)) state_d = qvt_pkg::ST_STORE;
			qvt_pkg::ST_STORE: begin
				if (idx_q == 2'd3) state_d = qvt_pkg::ST_DONE;
				else if (act_q == qvt_pkg::ACT_ROTATE) state_d = qvt_pkg::ST_LOAD;
			end
			qvt_pkg::ST_DONE:   if (out_ready) state_d = qvt_pkg::ST_IDLE;
			default:            state_d = qvt_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready  = (state_q == qvt_pkg::ST_IDLE);
		out_valid = (state_q == qvt_pkg::ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qvt_pkg::ST_IDLE;
			for (int i = 0; i < 4; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
			idx_q  <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				// Capture the item; simple actions update corners at once.
				qvt_pkg::ST_IDLE: if (in_valid) begin
					act_q <= qvt_pkg::action_t'(action);
					px_q  <= point_x;
					py_q  <= point_y;
					amt_q <= amount;
					idx_q <= '0;
					unique case (qvt_pkg::action_t'(action))
						qvt_pkg::ACT_SET: begin
							vx_q[0] <= corner0_x; vy_q[0] <= corner0_y;
							vx_q[1] <= corner1_x; vy_q[1] <= corner1_y;
							vx_q[2] <= corner2_x; vy_q[2] <= corner2_y;
							vx_q[3] <= corner3_x; vy_q[3] <= corner3_y;
						end
						qvt_pkg::ACT_ADD: begin
							vx_q[0] <= qvt_pkg::sat(EXT'(vx_q[0]) + EXT'(corner0_x));
							vy_q[0] <= qvt_pkg::sat(EXT'(vy_q[0]) + EXT'(corner0_y));
							vx_q[1] <= qvt_pkg::sat(EXT'(vx_q[1]) + EXT'(corner1_x));
							vy_q[1] <= qvt_pkg::sat(EXT'(vy_q[1]) + EXT'(corner1_y));
							vx_q[2] <= qvt_pkg::sat(EXT'(vx_q[2]) + EXT'(corner2_x));
							vy_q[2] <= qvt_pkg::sat(EXT'(vy_q[2]) + EXT'(corner2_y));
							vx_q[3] <= qvt_pkg::sat(EXT'(vx_q[3]) + EXT'(corner3_x));
							vy_q[3] <= qvt_pkg::sat(EXT'(vy_q[3]) + EXT'(corner3_y));
						end
						qvt_pkg::ACT_MOVE: begin
							for (int i = 0; i < 4; i++) begin
								vx_q[i] <= qvt_pkg::sat(EXT'(vx_q[i]) + EXT'(point_x));
								vy_q[i] <= qvt_pkg::sat(EXT'(vy_q[i]) + EXT'(point_y));
							end
						end
						default: ;
					endcase
				end
				// Centroid and quadrant split.
				qvt_pkg::ST_REDUCE: begin
					sx_q <= CW'(sumx >>> 2);
					sy_q <= CW'(sumy >>> 2);
					if (amod >= (AW_L+1)'(3 * qvt_pkg::QUARTER_TURN)) begin
						quad_q <= 2'd3;
						rest_q <= ZW'((amod - (AW_L+1)'(3 * qvt_pkg::QUARTER_TURN)) * 4096);
					end else if (amod >= (AW_L+1)'(2 * qvt_pkg::QUARTER_TURN)) begin
						quad_q <= 2'd2;
						rest_q <= ZW'((amod - (AW_L+1)'(2 * qvt_pkg::QUARTER_TURN)) * 4096);
					end else if (amod >= (AW_L+1)'(qvt_pkg::QUARTER_TURN)) begin
						quad_q <= 2'd1;
						rest_q <= ZW'((amod - (AW_L+1)'(qvt_pkg::QUARTER_TURN)) * 4096);
					end else begin
						quad_q <= 2'd0;
						rest_q <= ZW'(amod * 4096);
					end
				end
				qvt_pkg::ST_LOAD: begin
					step_q <= '0;
					if (on_pivot && amod != '0) idx_q <= idx_q + 2'd1;
				end
				qvt_pkg::ST_ITER: step_q <= step_q + SW'(1);
				// Write back one corner.
				qvt_pkg::ST_STORE: begin
					idx_q <= idx_q + 2'd1;
					if (act_q == qvt_pkg::ACT_ROTATE) begin
						vx_q[idx_q] <= qvt_pkg::sat(EXT'(px_q) + rx);
						vy_q[idx_q] <= qvt_pkg::sat(EXT'(py_q) + ry);
					end else if (act_q == qvt_pkg::ACT_SCALE) begin
						vx_q[idx_q] <= qvt_pkg::sat(EXT'((mx + 128) >>> 8));
						vy_q[idx_q] <= qvt_pkg::sat(EXT'((my + 128) >>> 8));
					end else begin
						vx_q[idx_q] <= qvt_pkg::sat(EXT'(vx_q[idx_q]) - EXT'(sx_q) + EXT'(px_q));
						vy_q[idx_q] <= qvt_pkg::sat(EXT'(vy_q[idx_q]) - EXT'(sy_q) + EXT'(py_q));
					end
				end
				default: ;
			endcase
		end
	end

	assign out_corner0_x = vx_q[0];
	assign out_corner0_y = vy_q[0];
	assign out_corner1_x = vx_q[1];
	assign out_corner1_y = vy_q[1];
	assign out_corner2_x = vx_q[2];
	assign out_corner2_y = vy_q[2];
	assign out_corner3_x = vx_q[3];
	assign out_corner3_y = vy_q[3];
	assign center_x = CW'(sumx >>> 2);
	assign center_y = CW'(sumy >>> 2);

endmodule
